>>> rtl/core/tlm_pkg.sv
// Package for the three-layer integer network: word types, layer and mode
// codes, sequencer states and fixed field widths. No dependencies.
`default_nettype none

package tlm_pkg;

    // Fixed field widths
    localparam int IDX_W       = 6;   // neuron and input indexes
    localparam int WGT_W       = 7;   // stored weight
    localparam int SENS_W      = 8;   // sensor vector
    localparam int L1_VAL_W    = 7;   // layer-1 output, at most 99
    localparam int L2_VAL_W    = 14;  // layer-2 output, at most 9801
    localparam int ACT_W       = 20;  // layer-3 activation
    localparam int MAX_RESULTS = 8;   // layer-3 neurons reported per run
    localparam logic [WGT_W-1:0] WEIGHT_CAP = 7'd99;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef enum logic [1:0] {
        LYR_1 = 2'd0,
        LYR_2 = 2'd1,
        LYR_3 = 2'd2
    } t_layer;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_RES   = 5'b10000
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [1:0]        layer_select;
        logic [IDX_W-1:0]  target_neuron;
        logic [IDX_W-1:0]  source_input;
        logic [WGT_W-1:0]  weight_value;
        logic [SENS_W-1:0] sensor_bits;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] out_neuron;
        logic [ACT_W-1:0] activation;
        logic             last_of_run;
    } t_out_word;

endpackage

`default_nettype wire

>>> rtl/core/three_layer_integer_mlp_top.sv
// Top level of the three-layer integer network: weight store, layer output
// stores, shared multiplier and sequencer. Uses tlm_pkg and tlm_ram.
//
//   channel  direction  handshake                  word
//   in       sink       i_in_valid / o_in_stall    tlm_pkg::t_in_word
//   out      source     o_out_valid / i_out_stall  tlm_pkg::t_out_word
//
// A load word writes one weight. A run word walks the three layers (at most
// eight layer-3 neurons), one weight read per cycle through the single weight
// RAM read port into the shared multiplier; each neuron then drains, divides
// by its fan-in and is stored or reported. The input stalls during a run.
// Reset (synchronous, active low) clears only the sequencer and valid flags.
// A stalled output holds; the sequencer waits on a full, stalled output register.
`default_nettype none

module three_layer_integer_mlp_top #(
    parameter int NUM_SENSORS = 8,
    parameter int LAYER1_SIZE = 8,
    parameter int LAYER2_SIZE = 8,
    parameter int LAYER3_SIZE = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tlm_pkg::t_in_word   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tlm_pkg::t_out_word       o_out_data
);

    // Layer 3 neurons that are ever read
    localparam int N3 = (LAYER3_SIZE > tlm_pkg::MAX_RESULTS) ?
                        tlm_pkg::MAX_RESULTS : LAYER3_SIZE;

    // Weight store layout: [layer][neuron][input], packed back to back
    localparam int BASE1  = LAYER1_SIZE * NUM_SENSORS;
    localparam int BASE2  = BASE1 + LAYER2_SIZE * LAYER1_SIZE;
    localparam int WDEPTH = BASE2 + N3 * LAYER2_SIZE;
    localparam int ADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int L1_AW  = (LAYER1_SIZE > 1) ? $clog2(LAYER1_SIZE) : 1;
    localparam int L2_AW  = (LAYER2_SIZE > 1) ? $clog2(LAYER2_SIZE) : 1;

    // Accumulator holds fan-in times the largest activation
    localparam int MAX_FAN0 = (NUM_SENSORS > LAYER1_SIZE) ? NUM_SENSORS : LAYER1_SIZE;
    localparam int MAX_FAN  = (MAX_FAN0 > LAYER2_SIZE) ? MAX_FAN0 : LAYER2_SIZE;
    localparam int ACC_W    = tlm_pkg::ACT_W + $clog2(MAX_FAN);
    localparam int PROD_W   = 2 * ACC_W + 1;
    localparam int OP_W     = tlm_pkg::L2_VAL_W;

    // Exact reciprocal division: q = (acc * M) >> S, M = ceil(2^S / fan-in)
    localparam int S0 = ACC_W + $clog2(NUM_SENSORS);
    localparam int S1 = ACC_W + $clog2(LAYER1_SIZE);
    localparam int S2 = ACC_W + $clog2(LAYER2_SIZE);
    localparam logic [63:0] M0_FULL = ((64'd1 << S0) + 64'(NUM_SENSORS) - 64'd1)
                                      / 64'(NUM_SENSORS);
    localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 64'(LAYER1_SIZE) - 64'd1)
                                      / 64'(LAYER1_SIZE);
    localparam logic [63:0] M2_FULL = ((64'd1 << S2) + 64'(LAYER2_SIZE) - 64'd1)
                                      / 64'(LAYER2_SIZE);
    localparam logic [ACC_W:0] M0 = M0_FULL[ACC_W:0];
    localparam logic [ACC_W:0] M1 = M1_FULL[ACC_W:0];
    localparam logic [ACC_W:0] M2 = M2_FULL[ACC_W:0];

    localparam logic [tlm_pkg::IDX_W:0] NS_C = (tlm_pkg::IDX_W+1)'(NUM_SENSORS);
    localparam logic [tlm_pkg::IDX_W:0] L1_C = (tlm_pkg::IDX_W+1)'(LAYER1_SIZE);
    localparam logic [tlm_pkg::IDX_W:0] L2_C = (tlm_pkg::IDX_W+1)'(LAYER2_SIZE);
    localparam logic [tlm_pkg::IDX_W:0] N3_C = (tlm_pkg::IDX_W+1)'(N3);

    // Sequencer and counters
    tlm_pkg::t_state          r_state, n_state;
    tlm_pkg::t_layer          r_layer, n_layer;
    logic [tlm_pkg::IDX_W-1:0]  r_nrn, n_nrn;
    logic [tlm_pkg::IDX_W-1:0]  r_src, n_src;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    logic [tlm_pkg::SENS_W-1:0] r_sens, n_sens;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic                       r_out_valid, n_out_valid;
    tlm_pkg::t_out_word         r_out, n_out;

    // MAC pipeline
    logic                r_v1, r_v2;
    logic                r_sbit1;
    logic [PROD_W-1:0]   r_prod;

    logic                      in_acc;
    logic                      issue;
    logic                      res_go;
    logic [tlm_pkg::IDX_W-1:0] last_src, last_nrn;
    logic                      sbit;
    logic [OP_W-1:0]           op;
    logic [ACC_W:0]            mul_a;
    logic [ACC_W-1:0]          mul_b;
    logic [ACC_W:0]            m_cur;
    logic [tlm_pkg::ACT_W-1:0] quot;

    logic                      ld_ok;
    logic [ADDR_W-1:0]         ld_addr;
    logic [tlm_pkg::WGT_W-1:0] ld_wgt;
    logic                      w_we;
    logic [ADDR_W-1:0]         w_raddr;
    logic [tlm_pkg::WGT_W-1:0] w_rd;

    logic                         l1_we, l2_we;
    logic [tlm_pkg::L1_VAL_W-1:0] l1_rd;
    logic [tlm_pkg::L2_VAL_W-1:0] l2_rd;

    assign o_in_stall = (r_state != tlm_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Load decode: drop loads outside the layer's size or fan-in
    always_comb begin
        ld_ok   = 1'b0;
        ld_addr = '0;
        unique case (i_in_data.layer_select)
            tlm_pkg::LYR_1: begin
                ld_ok   = ({1'b0, i_in_data.target_neuron} < L1_C) &&
                          ({1'b0, i_in_data.source_input} < NS_C);
                ld_addr = ADDR_W'(i_in_data.target_neuron) * ADDR_W'(NUM_SENSORS)
                          + ADDR_W'(i_in_data.source_input);
            end
            tlm_pkg::LYR_2: begin
                ld_ok   = ({1'b0, i_in_data.target_neuron} < L2_C) &&
                          ({1'b0, i_in_data.source_input} < L1_C);
                ld_addr = ADDR_W'(BASE1)
                          + ADDR_W'(i_in_data.target_neuron) * ADDR_W'(LAYER1_SIZE)
                          + ADDR_W'(i_in_data.source_input);
            end
            tlm_pkg::LYR_3: begin
                // neurons past the reported ones are never read: skip them
                ld_ok   = ({1'b0, i_in_data.target_neuron} < N3_C) &&
                          ({1'b0, i_in_data.source_input} < L2_C);
                ld_addr = ADDR_W'(BASE2)
                          + ADDR_W'(i_in_data.target_neuron) * ADDR_W'(LAYER2_SIZE)
                          + ADDR_W'(i_in_data.source_input);
            end
            default: begin
                ld_ok   = 1'b0;
                ld_addr = '0;
            end
        endcase
    end

    assign ld_wgt  = (i_in_data.weight_value > tlm_pkg::WEIGHT_CAP) ?
                     tlm_pkg::WEIGHT_CAP : i_in_data.weight_value;
    assign w_we    = in_acc && (i_in_data.mode == tlm_pkg::MODE_LOAD) && ld_ok;
    assign w_raddr = r_addr;

    tlm_ram #(
        .WIDTH (tlm_pkg::WGT_W),
        .DEPTH (WDEPTH)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_wgt),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Layer-1 and layer-2 outputs, read at the same input index as the weight
    tlm_ram #(
        .WIDTH (tlm_pkg::L1_VAL_W),
        .DEPTH (LAYER1_SIZE)
    ) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (r_nrn[L1_AW-1:0]),
        .i_wdata (quot[tlm_pkg::L1_VAL_W-1:0]),
        .i_raddr (r_src[L1_AW-1:0]),
        .o_rdata (l1_rd)
    );

    tlm_ram #(
        .WIDTH (tlm_pkg::L2_VAL_W),
        .DEPTH (LAYER2_SIZE)
    ) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (l2_we),
        .i_waddr (r_nrn[L2_AW-1:0]),
        .i_wdata (quot[tlm_pkg::L2_VAL_W-1:0]),
        .i_raddr (r_src[L2_AW-1:0]),
        .o_rdata (l2_rd)
    );

    // Per-layer fan-in, size and reciprocal
    always_comb begin
        unique case (r_layer)
            tlm_pkg::LYR_1: begin
                last_src = tlm_pkg::IDX_W'(NUM_SENSORS - 1);
                last_nrn = tlm_pkg::IDX_W'(LAYER1_SIZE - 1);
                m_cur    = M0;
                quot     = r_prod[S0 +: tlm_pkg::ACT_W];
            end
            tlm_pkg::LYR_2: begin
                last_src = tlm_pkg::IDX_W'(LAYER1_SIZE - 1);
                last_nrn = tlm_pkg::IDX_W'(LAYER2_SIZE - 1);
                m_cur    = M1;
                quot     = r_prod[S1 +: tlm_pkg::ACT_W];
            end
            tlm_pkg::LYR_3: begin
                last_src = tlm_pkg::IDX_W'(LAYER2_SIZE - 1);
                last_nrn = tlm_pkg::IDX_W'(N3 - 1);
                m_cur    = M2;
                quot     = r_prod[S2 +: tlm_pkg::ACT_W];
            end
            default: begin
                last_src = '0;
                last_nrn = '0;
                m_cur    = '0;
                quot     = '0;
            end
        endcase
    end

    // Sensors beyond the 8-bit field read as zero
    assign sbit = (r_src < tlm_pkg::IDX_W'(tlm_pkg::SENS_W)) ?
                  r_sens[r_src[$clog2(tlm_pkg::SENS_W)-1:0]] : 1'b0;

    // Operand that pairs with the weight arriving from the RAM
    always_comb begin
        case (r_layer)
            tlm_pkg::LYR_1: op = OP_W'(r_sbit1);
            tlm_pkg::LYR_2: op = OP_W'(l1_rd);
            default:        op = l2_rd;
        endcase
    end

    // Shared multiplier: weight * operand while accumulating,
    // accumulator * reciprocal when dividing by the fan-in
    always_comb begin
        if (r_state == tlm_pkg::ST_DIV) begin
            mul_a = m_cur;
            mul_b = r_acc;
        end else begin
            mul_a = (ACC_W+1)'(w_rd);
            mul_b = ACC_W'(op);
        end
    end

    // Hold the result stage while the output register is full and stalled
    assign res_go = !((r_layer == tlm_pkg::LYR_3) && r_out_valid && i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_layer     = r_layer;
        n_nrn       = r_nrn;
        n_src       = r_src;
        n_addr      = r_addr;
        n_sens      = r_sens;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_acc       = r_v2 ? (r_acc + r_prod[ACC_W-1:0]) : r_acc;
        issue       = 1'b0;
        l1_we       = 1'b0;
        l2_we       = 1'b0;

        unique case (r_state)
            tlm_pkg::ST_IDLE: begin
                if (in_acc && (i_in_data.mode == tlm_pkg::MODE_RUN)) begin
                    n_sens  = i_in_data.sensor_bits;
                    n_layer = tlm_pkg::LYR_1;
                    n_nrn   = '0;
                    n_src   = '0;
                    n_addr  = '0;
                    n_acc   = '0;
                    n_state = tlm_pkg::ST_MAC;
                end
            end
            tlm_pkg::ST_MAC: begin
                // issue one weight read per cycle, walking the store in order
                issue  = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_src == last_src) begin
                    n_src   = '0;
                    n_state = tlm_pkg::ST_DRAIN;
                end else begin
                    n_src = r_src + tlm_pkg::IDX_W'(1);
                end
            end
            tlm_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = tlm_pkg::ST_DIV;
                end
            end
            tlm_pkg::ST_DIV: begin
                n_state = tlm_pkg::ST_RES;
            end
            tlm_pkg::ST_RES: begin
                if (res_go) begin
                    case (r_layer)
                        tlm_pkg::LYR_1: l1_we = 1'b1;
                        tlm_pkg::LYR_2: l2_we = 1'b1;
                        default: begin
                            n_out_valid       = 1'b1;
                            n_out.out_neuron  = r_nrn;
                            n_out.activation  = quot;
                            n_out.last_of_run = (r_nrn == last_nrn);
                        end
                    endcase
                    n_acc = '0;
                    if (r_nrn == last_nrn) begin
                        n_nrn = '0;
                        case (r_layer)
                            tlm_pkg::LYR_1: begin
                                n_layer = tlm_pkg::LYR_2;
                                n_state = tlm_pkg::ST_MAC;
                            end
                            tlm_pkg::LYR_2: begin
                                n_layer = tlm_pkg::LYR_3;
                                n_state = tlm_pkg::ST_MAC;
                            end
                            default: begin
                                n_state = tlm_pkg::ST_IDLE;
                            end
                        endcase
                    end else begin
                        n_nrn   = r_nrn + tlm_pkg::IDX_W'(1);
                        n_state = tlm_pkg::ST_MAC;
                    end
                end
            end
            default: begin
                n_state = tlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlm_pkg::ST_IDLE;
            r_layer     <= tlm_pkg::LYR_1;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_layer     <= n_layer;
            r_out_valid <= n_out_valid;
            r_v1        <= issue;
            r_v2        <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nrn   <= n_nrn;
        r_src   <= n_src;
        r_addr  <= n_addr;
        r_sens  <= n_sens;
        r_acc   <= n_acc;
        r_out   <= n_out;
        r_sbit1 <= sbit;
        // keep the quotient product while the result stage waits
        if (r_state != tlm_pkg::ST_RES) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The division must see a fully drained accumulate pipeline
    a_div_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlm_pkg::ST_DIV) |-> (!r_v1 && !r_v2))
        else $error("division started with products in flight");

    // Each neuron starts from a cleared accumulator
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlm_pkg::ST_MAC && $past(r_state) != tlm_pkg::ST_MAC)
        |-> (r_acc == '0 && !r_v2))
        else $error("neuron started with a stale accumulator");

    // A new result only comes from the layer-3 result stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall))
        |-> $past(r_state == tlm_pkg::ST_RES && r_layer == tlm_pkg::LYR_3))
        else $error("result appeared outside the layer-3 result stage");

    // Reads are issued only by the accumulate state
    a_issue_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state == tlm_pkg::ST_MAC))
        else $error("weight read in flight without an issue");

endmodule

`default_nettype wire

>>> rtl/core/tlm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> bench/tb_three_layer_integer_mlp_top.sv
// Self-checking bench for three_layer_integer_mlp_top: weight fill, directed table, then
// random load and run words under four flow-control phases, checked against a predictor.
// Depends on tlm_pkg and the network RTL.

module tb_three_layer_integer_mlp_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Network shape, kept equal to the defaults of the block
    localparam int NUM_SENSORS = 8;
    localparam int LAYER1_SIZE = 8;
    localparam int LAYER2_SIZE = 8;
    localparam int LAYER3_SIZE = 8;
    localparam int N_REPORTED  = (LAYER3_SIZE < tlm_pkg::MAX_RESULTS) ?
                                 LAYER3_SIZE : tlm_pkg::MAX_RESULTS;
    localparam int MAX_DIM     = 64;
    localparam int IN_W        = $bits(tlm_pkg::t_in_word);

    // Layer code that names no layer; loads carrying it must be dropped
    localparam logic [1:0] LYR_NONE = 2'd3;

    localparam logic [tlm_pkg::ACT_W-1:0] ACT_PEAK = 20'd970299;  // 99 * 9801
    localparam logic [tlm_pkg::ACT_W-1:0] ACT_ZERO = '0;
    localparam logic [tlm_pkg::WGT_W-1:0] WGT_MAX  = 7'd127;

    localparam int DRAIN_CYCLES    = 400;   // idle time after the last owed result
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles without any accepted word
    localparam int ITEMS_PER_PHASE = 6;
    localparam int NOISE_PCT       = 10;
    localparam int RUN_PCT         = 40;

    typedef struct packed {
        tlm_pkg::t_in_word         word;
        logic                      typed;  // 1: act is the expected activation of every neuron
        logic [tlm_pkg::ACT_W-1:0] act;
    } t_dir_row;

    // Directed table. The weight store holds 99 everywhere when it starts.
    localparam t_dir_row DIR_TABLE [22] = '{
        // all sensors on, unused fields all ones: peak activation on every neuron
        '{'{tlm_pkg::MODE_RUN,  LYR_NONE,       6'd63, 6'd63, 7'd127, 8'hFF}, 1'b1, ACT_PEAK},
        // no sensor on: every layer collapses to zero
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h00}, 1'b1, ACT_ZERO},
        // out-of-range loads: bad layer, neuron past the layer, input past the fan-in
        '{'{tlm_pkg::MODE_LOAD, LYR_NONE,       6'd0,  6'd0,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_1, 6'd8,  6'd0,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_1, 6'd63, 6'd63, 7'd0,   8'hFF}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_2, 6'd0,  6'd8,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_3, 6'd63, 6'd0,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        // none of those may have landed: still the peak
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'hFF}, 1'b1, ACT_PEAK},
        // in-range loads: zero, mid, one, clamp at 100 and at 127
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_1, 6'd7,  6'd7,  7'd50,  8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_2, 6'd7,  6'd7,  7'd1,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_2, 6'd0,  6'd3,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_3, 6'd3,  6'd5,  7'd100, 8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_3, 6'd0,  6'd0,  7'd127, 8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_3, 6'd7,  6'd7,  7'd0,   8'h00}, 1'b0, ACT_ZERO},
        // single sensors, alternating and dense patterns, and one layer-3 reload
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h01}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h80}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h55}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'hAA}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'hFF}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_LOAD, tlm_pkg::LYR_3, 6'd7,  6'd7,  7'd99,  8'h00}, 1'b0, ACT_ZERO},
        '{'{tlm_pkg::MODE_RUN,  tlm_pkg::LYR_1, 6'd0,  6'd0,  7'd0,   8'h7F}, 1'b0, ACT_ZERO}
    };

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    tlm_pkg::t_in_word  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    tlm_pkg::t_out_word out_data;

    // Flow-control knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int err_count    = 0;
    int quiet_cycles = 0;

    // Predictor state: a copy of the weight store and the activations still owed
    logic [tlm_pkg::WGT_W-1:0] weight_copy [3][MAX_DIM][MAX_DIM];
    tlm_pkg::t_out_word        expected_acts [$];
    tlm_pkg::t_out_word        want;

    three_layer_integer_mlp_top #(
        .NUM_SENSORS (NUM_SENSORS),
        .LAYER1_SIZE (LAYER1_SIZE),
        .LAYER2_SIZE (LAYER2_SIZE),
        .LAYER3_SIZE (LAYER3_SIZE)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int layer_size(input logic [1:0] layer);
        case (layer)
            tlm_pkg::LYR_1: return LAYER1_SIZE;
            tlm_pkg::LYR_2: return LAYER2_SIZE;
            default:        return LAYER3_SIZE;
        endcase
    endfunction

    function automatic int layer_fan_in(input logic [1:0] layer);
        case (layer)
            tlm_pkg::LYR_1: return NUM_SENSORS;
            tlm_pkg::LYR_2: return LAYER1_SIZE;
            default:        return LAYER2_SIZE;
        endcase
    endfunction

    // Append one owed word at the tail of the expected queue.
    function automatic void owe_result(input tlm_pkg::t_out_word res);
        expected_acts.insert(expected_acts.size(), res);
    endfunction

    // Evaluate the three layers on the weight copy and queue one word per reported neuron.
    function automatic void predict_activations(input logic [tlm_pkg::SENS_W-1:0] sens);
        int unsigned        first_out  [MAX_DIM];
        int unsigned        second_out [MAX_DIM];
        int unsigned        acc;
        tlm_pkg::t_out_word res;
        for (int i = 0; i < LAYER1_SIZE; i++) begin
            acc = 0;
            for (int j = 0; j < NUM_SENSORS; j++) begin
                // sensors past the field read as off
                if (j < tlm_pkg::SENS_W && sens[j]) begin
                    acc += weight_copy[tlm_pkg::LYR_1][i][j];
                end
            end
            first_out[i] = acc / NUM_SENSORS;
        end
        for (int i = 0; i < LAYER2_SIZE; i++) begin
            acc = 0;
            for (int j = 0; j < LAYER1_SIZE; j++) begin
                acc += weight_copy[tlm_pkg::LYR_2][i][j] * first_out[j];
            end
            second_out[i] = acc / LAYER1_SIZE;
        end
        for (int i = 0; i < N_REPORTED; i++) begin
            acc = 0;
            for (int j = 0; j < LAYER2_SIZE; j++) begin
                acc += weight_copy[tlm_pkg::LYR_3][i][j] * second_out[j];
            end
            res.out_neuron  = tlm_pkg::IDX_W'(i);
            res.activation  = tlm_pkg::ACT_W'(acc / LAYER2_SIZE);
            res.last_of_run = (i == N_REPORTED - 1);
            owe_result(res);
        end
    endfunction

    function automatic logic [tlm_pkg::WGT_W-1:0] pick_weight();
        case ($urandom_range(3))
            0:       return '0;
            1:       return tlm_pkg::WEIGHT_CAP;
            2:       return tlm_pkg::WGT_W'($urandom_range(127, 100));
            default: return tlm_pkg::WGT_W'($urandom_range(127));
        endcase
    endfunction

    function automatic tlm_pkg::t_in_word make_load(input logic [1:0] layer,
                                                    input int neuron, input int source,
                                                    input logic [tlm_pkg::WGT_W-1:0] weight);
        tlm_pkg::t_in_word w;
        w.mode          = tlm_pkg::MODE_LOAD;
        w.layer_select  = layer;
        w.target_neuron = tlm_pkg::IDX_W'(neuron);
        w.source_input  = tlm_pkg::IDX_W'(source);
        w.weight_value  = weight;
        w.sensor_bits   = tlm_pkg::SENS_W'($urandom);  // ignored on a load
        return w;
    endfunction

    // Offer one word, hold it until accepted, then update the predictor.
    task automatic send_word(input tlm_pkg::t_in_word w, input logic typed,
                             input logic [tlm_pkg::ACT_W-1:0] act);
        tlm_pkg::t_out_word res;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        if (w.mode == tlm_pkg::MODE_LOAD) begin
            // drop loads that address no weight; clamp the rest
            if (w.layer_select != LYR_NONE
                    && w.target_neuron < layer_size(w.layer_select)
                    && w.source_input < layer_fan_in(w.layer_select)) begin
                weight_copy[w.layer_select][w.target_neuron][w.source_input] =
                    (w.weight_value > tlm_pkg::WEIGHT_CAP) ?
                    tlm_pkg::WEIGHT_CAP : w.weight_value;
            end
        end else if (typed) begin
            for (int i = 0; i < N_REPORTED; i++) begin
                res.out_neuron  = tlm_pkg::IDX_W'(i);
                res.activation  = act;
                res.last_of_run = (i == N_REPORTED - 1);
                owe_result(res);
            end
        end else begin
            predict_activations(w.sensor_bits);
        end
    endtask

    // Write every weight of every layer, so no run ever reads an unwritten entry.
    task automatic fill_weights(input logic rand_values);
        for (int l = 0; l < 3; l++) begin
            for (int n = 0; n < layer_size(2'(l)); n++) begin
                for (int s = 0; s < layer_fan_in(2'(l)); s++) begin
                    send_word(make_load(2'(l), n, s, rand_values ? pick_weight() : WGT_MAX),
                              1'b0, ACT_ZERO);
                end
            end
        end
    endtask

    // Drop valid and hold off until every owed activation has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_acts.size() != 0);
    endtask

    // One random phase: mostly in-range loads and runs, some out-of-range loads as noise.
    task automatic run_phase(input int send_pct, input int recv_pct);
        int                counted;
        int                roll;
        int                l;
        tlm_pkg::t_in_word w;
        wait_for_results();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        counted = 0;
        while (counted < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            l    = $urandom_range(2);
            if (roll < NOISE_PCT) begin
                w = IN_W'($urandom);
                w.mode = tlm_pkg::MODE_LOAD;
                case ($urandom_range(2))
                    0: w.layer_select = LYR_NONE;
                    1: begin
                        w.layer_select  = 2'(l);
                        w.target_neuron = tlm_pkg::IDX_W'($urandom_range(63,
                                                          layer_size(2'(l))));
                    end
                    default: begin
                        w.layer_select = 2'(l);
                        w.source_input = tlm_pkg::IDX_W'($urandom_range(63,
                                                         layer_fan_in(2'(l))));
                    end
                endcase
            end else if (roll < NOISE_PCT + RUN_PCT) begin
                // unused fields stay random on a run
                w = IN_W'($urandom);
                w.mode = tlm_pkg::MODE_RUN;
                counted++;
            end else begin
                w = make_load(2'(l), $urandom_range(layer_size(2'(l)) - 1),
                              $urandom_range(layer_fan_in(2'(l)) - 1), pick_weight());
                counted++;
            end
            send_word(w, 1'b0, ACT_ZERO);
        end
    endtask

    // Receiver side: stall at the rate of the current phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check each accepted output word against the oldest owed activation and
    // watch for a hung handshake.
    always @(posedge clk) begin
        if (rst_n) begin
            quiet_cycles++;
            if (in_valid && !in_stall) begin
                quiet_cycles = 0;
            end
            if (out_valid && !out_stall) begin
                quiet_cycles = 0;
                if (expected_acts.size() == 0) begin
                    $display("%0t: unexpected word: neuron %0d activation %0d last %0b",
                             $time, out_data.out_neuron, out_data.activation,
                             out_data.last_of_run);
                    err_count++;
                end else begin
                    want = expected_acts.pop_front();
                    if (out_data.out_neuron !== want.out_neuron) begin
                        $display("%0t: out_neuron expected %0d actual %0d",
                                 $time, want.out_neuron, out_data.out_neuron);
                        err_count++;
                    end
                    if (out_data.activation !== want.activation) begin
                        $display("%0t: activation of neuron %0d expected %0d actual %0d",
                                 $time, want.out_neuron, want.activation,
                                 out_data.activation);
                        err_count++;
                    end
                    if (out_data.last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run of neuron %0d expected %0b actual %0b",
                                 $time, want.out_neuron, want.last_of_run,
                                 out_data.last_of_run);
                        err_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Load 127 everywhere; the clamp must leave 99 in every entry.
        fill_weights(1'b0);
        foreach (DIR_TABLE[k]) begin
            send_word(DIR_TABLE[k].word, DIR_TABLE[k].typed, DIR_TABLE[k].act);
        end

        // Random phases: free flow, sparse sender, stalling receiver, both a little.
        run_phase(0, 0);
        run_phase(74, 0);
        run_phase(0, 74);
        run_phase(14, 14);

        // Drain: collect every owed word, then idle out the run latency.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tlm_pkg.sv
rtl/core/tlm_ram.sv
rtl/core/three_layer_integer_mlp_top.sv
bench/tb_three_layer_integer_mlp_top.sv
